[hdl/nsc_pkg.sv]
`default_nettype none

package nsc_pkg;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;
	localparam int SAMPLE_W = 16;
	localparam int CORR_OUT_W = 38;
	localparam int ENERGY_OUT_W = 37;
	localparam int NORM_W = 16;
	localparam int TAP_INDEX_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_TAP_INDEX = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_VALUE = 4'd1;

	typedef struct packed {
		logic busy;
		logic done;
	} mac_stat_t;

endpackage

`default_nettype wire

[hdl/nsc_mac.sv]
`default_nettype none

module nsc_mac #(
	parameter int LENGTH = 64
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire logic signed [15:0]             sample_in,
	input  wire                                 cfg_we,
	input  wire logic [nsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [nsc_pkg::CFG_DATA_W-1:0] cfg_data,
	output nsc_pkg::mac_stat_t                  stat,
	output logic signed [35+$clog2(LENGTH+1)-1:0] corr,
	output logic [34+$clog2(LENGTH+1)-1:0]      energy,
	output logic [34+$clog2(LENGTH+1)-1:0]      tap_energy
);

	localparam int AW = (LENGTH > 1) ? $clog2(LENGTH) : 1;
	localparam int IW = $clog2(LENGTH + 1);
	localparam int CW = 35 + $clog2(LENGTH + 1);
	localparam int EW = CW - 1;
	localparam int TW = nsc_pkg::TAP_INDEX_W;

	typedef enum logic [4:0] {
		MS_IDLE  = 5'b00001,
		MS_SWEEP = 5'b00010,
		MS_STORE = 5'b00100,
		MS_TMUL  = 5'b01000,
		MS_TACC  = 5'b10000
	} mac_state_t;

	mac_state_t state_q;

	logic signed [15:0] win_mem [LENGTH];
	logic signed [15:0] tap_mem [LENGTH];
	logic [LENGTH-1:0]  win_vld_q, tap_vld_q;
	logic signed [15:0] win_rd_q, tap_rd_q;
	logic               win_vr_q, tap_vr_q;

	logic [AW-1:0]      ptr_q;
	logic [IW-1:0]      cnt_q;
	logic               s1_q, s2_q;
	logic [TW-1:0]      tap_index_q;
	logic signed [15:0] tap_new_q;
	logic signed [15:0] sample_q;
	logic signed [CW-1:0] acc_c_q;
	logic [EW-1:0]      acc_e_q;
	logic [EW-1:0]      tap_energy_q;
	logic signed [33:0] prod_c_s2;
	logic signed [31:0] prod_e_s2;

	logic [AW+TW-1:0]   tix_ext;
	logic [AW-1:0]      tix, tap_addr, win_addr;
	logic [AW:0]        wsum;
	logic               issue, tap_in_range, tap_write_req;
	logic signed [15:0] w, t, old_tap;
	logic signed [16:0] ma, mb;

	assign tix_ext = {{AW{1'b0}}, tap_index_q};
	assign tix = tix_ext[AW-1:0];
	assign tap_in_range = int'(tap_index_q) < LENGTH;
	assign tap_write_req = cfg_we && (cfg_index == nsc_pkg::CFG_TAP_VALUE) && tap_in_range;
	assign issue = (state_q == MS_SWEEP) && (cnt_q != IW'(LENGTH));

	// oldest sample sits at the write pointer
	assign wsum = {1'b0, ptr_q} + {1'b0, cnt_q[AW-1:0]};
	assign win_addr = (wsum >= (AW+1)'(LENGTH)) ? AW'(wsum - (AW+1)'(LENGTH)) : wsum[AW-1:0];
	assign tap_addr = (state_q == MS_SWEEP) ? cnt_q[AW-1:0] : tix;

	assign w = win_vr_q ? win_rd_q : 16'sd0;
	assign t = tap_vr_q ? tap_rd_q : 16'sd0;
	assign old_tap = tap_vr_q ? tap_rd_q : 16'sd0;

	always_comb begin
		if (state_q == MS_TMUL) begin
			// new^2 - old^2 as one product
			ma = {tap_new_q[15], tap_new_q} - {old_tap[15], old_tap};
			mb = {tap_new_q[15], tap_new_q} + {old_tap[15], old_tap};
		end else begin
			ma = {w[15], w};
			mb = {t[15], t};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MS_STORE) begin
			win_mem[ptr_q] <= sample_q;
		end
		win_rd_q <= win_mem[win_addr];
		if (state_q == MS_TMUL) begin
			tap_mem[tix] <= tap_new_q;
		end
		tap_rd_q <= tap_mem[tap_addr];
		prod_c_s2 <= ma * mb;
		prod_e_s2 <= w * w;
		if (start) begin
			sample_q <= sample_in;
		end
		if (cfg_we && (cfg_index == nsc_pkg::CFG_TAP_VALUE)) begin
			tap_new_q <= $signed(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			win_vld_q <= '0;
			tap_vld_q <= '0;
			win_vr_q <= 1'b0;
			tap_vr_q <= 1'b0;
			ptr_q <= '0;
			cnt_q <= '0;
			s1_q <= 1'b0;
			s2_q <= 1'b0;
			tap_index_q <= '0;
			acc_c_q <= '0;
			acc_e_q <= '0;
			tap_energy_q <= '0;
		end else begin
			win_vr_q <= win_vld_q[win_addr];
			tap_vr_q <= tap_vld_q[tap_addr];
			s1_q <= issue;
			s2_q <= s1_q;
			if (cfg_we && (cfg_index == nsc_pkg::CFG_TAP_INDEX)) begin
				tap_index_q <= cfg_data[TW-1:0];
			end
			case (state_q)
				MS_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						acc_c_q <= '0;
						acc_e_q <= '0;
						state_q <= MS_SWEEP;
					end else if (tap_write_req) begin
						state_q <= MS_TMUL;
					end
				end
				MS_SWEEP: begin
					if (issue) begin
						cnt_q <= cnt_q + IW'(1);
					end
					if (s2_q) begin
						acc_c_q <= acc_c_q + {{(CW-34){prod_c_s2[33]}}, prod_c_s2};
						acc_e_q <= acc_e_q + {{(EW-32){prod_e_s2[31]}}, prod_e_s2};
					end
					if (!issue && !s1_q && !s2_q) begin
						state_q <= MS_STORE;
					end
				end
				MS_STORE: begin
					win_vld_q[ptr_q] <= 1'b1;
					ptr_q <= (ptr_q == AW'(LENGTH - 1)) ? '0 : ptr_q + AW'(1);
					state_q <= MS_IDLE;
				end
				MS_TMUL: begin
					tap_vld_q[tix] <= 1'b1;
					state_q <= MS_TACC;
				end
				MS_TACC: begin
					tap_energy_q <= tap_energy_q + {{(EW-34){prod_c_s2[33]}}, prod_c_s2};
					state_q <= MS_IDLE;
				end
				default: begin
					state_q <= MS_IDLE;
				end
			endcase
		end
	end

	assign stat.busy = (state_q != MS_IDLE);
	assign stat.done = (state_q == MS_STORE);
	assign corr = acc_c_q;
	assign energy = acc_e_q;
	assign tap_energy = tap_energy_q;

endmodule

`default_nettype wire

[hdl/nsc_norm.sv]
`default_nettype none

module nsc_norm #(
	parameter int LENGTH = 64
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire logic signed [35+$clog2(LENGTH+1)-1:0] corr,
	input  wire logic [34+$clog2(LENGTH+1)-1:0]   aa,
	input  wire logic [34+$clog2(LENGTH+1)-1:0]   bb,
	output logic                                  done,
	output logic signed [15:0]                    result
);

	localparam int CW = 35 + $clog2(LENGTH + 1);
	localparam int EW = CW - 1;
	localparam int NW = 2 * EW + 36;
	localparam int BW = $clog2(CW + 1);

	typedef enum logic [5:0] {
		N_IDLE = 6'b000001,
		N_MULD = 6'b000010,
		N_MULS = 6'b000100,
		N_RA   = 6'b001000,
		N_RB   = 6'b010000,
		N_DONE = 6'b100000
	} norm_state_t;

	norm_state_t state_q;

	logic [CW-1:0]        mag_q, mpl_q;
	logic [NW-1:0]        acc_q, mcd_q;
	logic [BW-1:0]        cnt_q;
	logic signed [NW-1:0] d_q, l_q, p_q, qs_q, ds_q, t_q, u_q;
	logic [15:0]          m_q;
	logic [3:0]           bit_q;
	logic                 neg_q;
	logic signed [NW-1:0] t2;
	logic [CW-1:0]        corr_mag;

	assign corr_mag = corr[CW-1] ? $unsigned(-corr) : $unsigned(corr);
	assign t2 = t_q + ds_q;

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				mag_q <= corr_mag;
				acc_q <= '0;
				mcd_q <= {{(NW-EW){1'b0}}, aa};
				mpl_q <= {1'b0, bb};
			end
			N_MULD: begin
				if (cnt_q == BW'(EW)) begin
					d_q <= $signed(acc_q);
					acc_q <= '0;
					mcd_q <= {{(NW-CW){1'b0}}, mag_q};
					mpl_q <= mag_q;
				end else begin
					if (mpl_q[0]) begin
						acc_q <= acc_q + mcd_q;
					end
					mcd_q <= mcd_q << 1;
					mpl_q <= mpl_q >> 1;
				end
			end
			N_MULS: begin
				if (cnt_q == BW'(CW)) begin
					// running odd-square search, odd starts at -1
					l_q <= $signed(acc_q << 32);
					p_q <= d_q;
					qs_q <= -(d_q <<< 17);
					ds_q <= d_q <<< 32;
				end else begin
					if (mpl_q[0]) begin
						acc_q <= acc_q + mcd_q;
					end
					mcd_q <= mcd_q << 1;
					mpl_q <= mpl_q >> 1;
				end
			end
			N_RA: begin
				t_q <= p_q + qs_q;
				u_q <= qs_q + (ds_q <<< 1);
			end
			N_RB: begin
				if (t2 <= l_q) begin
					p_q <= t2;
					qs_q <= u_q >>> 1;
				end else begin
					qs_q <= qs_q >>> 1;
				end
				ds_q <= ds_q >>> 2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q <= '0;
			bit_q <= '0;
			m_q <= '0;
			neg_q <= 1'b0;
		end else begin
			case (state_q)
				N_IDLE: begin
					if (start) begin
						m_q <= '0;
						cnt_q <= '0;
						bit_q <= 4'd15;
						neg_q <= corr[CW-1];
						if ((aa == '0) || (bb == '0)) begin
							neg_q <= 1'b0;
							state_q <= N_DONE;
						end else begin
							state_q <= N_MULD;
						end
					end
				end
				N_MULD: begin
					if (cnt_q == BW'(EW)) begin
						cnt_q <= '0;
						state_q <= N_MULS;
					end else begin
						cnt_q <= cnt_q + BW'(1);
					end
				end
				N_MULS: begin
					if (cnt_q == BW'(CW)) begin
						state_q <= N_RA;
					end else begin
						cnt_q <= cnt_q + BW'(1);
					end
				end
				N_RA: begin
					state_q <= N_RB;
				end
				N_RB: begin
					if (t2 <= l_q) begin
						m_q[bit_q] <= 1'b1;
					end
					if (bit_q == 4'd0) begin
						state_q <= N_DONE;
					end else begin
						bit_q <= bit_q - 4'd1;
						state_q <= N_RA;
					end
				end
				N_DONE: begin
					state_q <= N_IDLE;
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

	assign done = (state_q == N_DONE);
	assign result = neg_q ? $signed(~m_q + 16'd1)
		: (m_q[15] ? 16'sh7fff : $signed(m_q));

endmodule

`default_nettype wire

[hdl/normalised_sliding_correlator.sv]
// sample to result: the multiply-accumulate sweep, the window store, the two shift-add products
// (CW = 35 + clog2(LENGTH+1)), the 16-bit root/divide search, done and the output load,
// in that order
// input stalls while anything is in flight, so a new sample waits until the last result is loaded
// a zero tap or window energy skips the normalizer products and search
// reset (arst_n, async, low) clears window, taps, tap energy and all control at once
`default_nettype none

module normalised_sliding_correlator #(
	parameter int LENGTH = 64
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// sample channel
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire logic signed [15:0]             sample,
	// result channel
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic signed [37:0]                  correlation,
	output logic [36:0]                         window_energy,
	output logic signed [15:0]                  normalised_correlation,
	// register writes
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [nsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [nsc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = 35 + $clog2(LENGTH + 1);
	localparam int EW = CW - 1;

	typedef enum logic [3:0] {
		TS_IDLE = 4'b0001,
		TS_MAC  = 4'b0010,
		TS_NORM = 4'b0100,
		TS_OUT  = 4'b1000
	} top_state_t;

	top_state_t state_q;

	nsc_pkg::mac_stat_t   mac_stat;
	logic signed [CW-1:0] corr;
	logic [EW-1:0]        energy, tap_energy;
	logic                 norm_done;
	logic signed [15:0]   norm_result;
	logic                 in_accept, cfg_we, out_load;
	logic                 out_valid_q;
	logic [CW+37:0]       corr_wide;
	logic [EW+36:0]       energy_wide;

	// a sample goes in only when nothing is in flight, tap updates included
	// a pending register write takes the cycle before a sample
	assign in_stall = (state_q != TS_IDLE) || mac_stat.busy || cfg_valid;
	assign in_accept = in_valid && !in_stall;
	// register writes only while no sample is in flight
	assign cfg_ready = (state_q == TS_IDLE) && !mac_stat.busy;
	assign cfg_we = cfg_valid && cfg_ready;

	// output register loads once the last result is taken; a stalled result holds the core
	assign out_load = (state_q == TS_OUT) && (!out_valid_q || !out_stall);

	// sums are exact internally, the ports wrap them to field width
	assign corr_wide = {{38{corr[CW-1]}}, corr};
	assign energy_wide = {37'b0, energy};

	nsc_mac #(
		.LENGTH(LENGTH)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_accept),
		.sample_in  (sample),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.stat       (mac_stat),
		.corr       (corr),
		.energy     (energy),
		.tap_energy (tap_energy)
	);

	nsc_norm #(
		.LENGTH(LENGTH)
	) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_stat.done),
		.corr   (corr),
		.aa     (tap_energy),
		.bb     (energy),
		.done   (norm_done),
		.result (norm_result)
	);

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_load) begin
			correlation <= $signed(corr_wide[37:0]);
			window_energy <= energy_wide[36:0];
			normalised_correlation <= norm_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				TS_IDLE: begin
					if (in_accept) begin
						state_q <= TS_MAC;
					end
				end
				TS_MAC: begin
					if (mac_stat.done) begin
						state_q <= TS_NORM;
					end
				end
				TS_NORM: begin
					if (norm_done) begin
						state_q <= TS_OUT;
					end
				end
				TS_OUT: begin
					if (out_load) begin
						state_q <= TS_IDLE;
					end
				end
				default: begin
					state_q <= TS_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == TS_MAC)
		else $error("accepted sample did not start the sweep");
	a_mac_done: assert property (@(posedge clk) disable iff (!arst_n)
		mac_stat.done |-> state_q == TS_MAC)
		else $error("sweep finished outside the sweep phase");
	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		norm_done |-> state_q == TS_NORM)
		else $error("normalizer finished outside its phase");
`endif

endmodule

`default_nettype wire

[test/normalised_sliding_correlator_tb.sv]
`default_nettype none

module normalised_sliding_correlator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_LEN = 64;
	// the settle tail covers one full item
	localparam int SETTLE_CYCLES = 300;
	// the long receiver hold-off stays well under the watchdog limit
	localparam int LONG_HOLD = 600;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MAX_PRINTED = 20;

	// one expected output transaction
	typedef struct {
		logic signed [37:0] corr;
		logic [36:0] energy;
		logic signed [15:0] norm;
	} corr_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] sample;
	logic out_valid;
	logic out_stall;
	logic signed [37:0] correlation;
	logic [36:0] window_energy;
	logic signed [15:0] normalised_correlation;
	logic cfg_valid;
	logic cfg_ready;
	logic [nsc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [nsc_pkg::CFG_DATA_W-1:0] cfg_data;

	normalised_sliding_correlator #(
		.LENGTH(WIN_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.correlation(correlation),
		.window_energy(window_energy),
		.normalised_correlation(normalised_correlation),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// samples waiting to be offered, filled by the stimulus process
	logic signed [15:0] pending_samples[$];
	// expected results in arrival order
	corr_result_t expected_results[$];

	// shadow copy of the block state
	logic signed [15:0] win_samples[WIN_LEN];
	int win_head;
	logic signed [15:0] coeffs[WIN_LEN];
	longint coeff_energy;
	logic [5:0] coeff_sel;

	// knobs set by the stimulus process
	bit idle_enable;
	int hold_epoch;

	int send_gap;
	int stall_left;
	int hold_left;
	int hold_seen;
	int idle_cycles;
	int error_count;
	int samples_sent;
	int results_checked;
	int cfg_writes;
	int saturated_seen;
	int zero_norm_seen;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// exact q1.15 of corr / sqrt(ea * eb), round half up, saturated
	function automatic logic signed [15:0] norm_q15(input longint c, input longint ea,
			input longint eb);
		logic [191:0] den;
		logic [191:0] lim;
		logic [191:0] prod;
		logic [191:0] odd;
		logic [63:0] mag;
		logic [16:0] m;
		logic [16:0] trial;
		m = '0;
		if (ea == 0 || eb == 0)
			return '0;
		mag = (c < 0) ? -c : c;
		den = 192'(ea) * 192'(eb);
		lim = (192'(mag) * 192'(mag)) << 32;
		for (int b = 15; b >= 0; b--) begin
			trial = m | (17'd1 << b);
			odd = 192'(2 * trial - 1);
			prod = odd * odd * den;
			if (prod <= lim)
				m = trial;
		end
		if (c < 0)
			return 16'(-m);
		return (m > 17'd32767) ? 16'sd32767 : 16'(m);
	endfunction

	// result for the current window, then the new sample enters it
	function automatic corr_result_t predict_and_shift(input logic signed [15:0] s);
		corr_result_t r;
		longint acc;
		longint en;
		longint w;
		acc = 0;
		en = 0;
		for (int i = 0; i < WIN_LEN; i++) begin
			w = win_samples[(win_head + i) % WIN_LEN];
			acc += w * longint'(coeffs[i]);
			en += w * w;
		end
		r.corr = acc[37:0];
		r.energy = en[36:0];
		r.norm = norm_q15(acc, coeff_energy, en);
		win_samples[win_head] = s;
		win_head = (win_head + 1) % WIN_LEN;
		return r;
	endfunction

	function automatic void apply_cfg(input logic [nsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [nsc_pkg::CFG_DATA_W-1:0] data);
		logic signed [15:0] old;
		case (idx)
			nsc_pkg::CFG_TAP_INDEX: begin
				coeff_sel = data[nsc_pkg::TAP_INDEX_W-1:0];
			end
			nsc_pkg::CFG_TAP_VALUE: begin
				// tap index is six bits, so it always lands inside the store
				old = coeffs[coeff_sel];
				coeff_energy -= longint'(old) * old;
				coeff_energy += longint'($signed(data)) * $signed(data);
				coeffs[coeff_sel] = data;
			end
			default: begin
				// unused register index, no effect
			end
		endcase
	endfunction

	// sender: pops pending samples, random bursts of idle cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			send_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (idle_enable && pending_samples.size() > 0
					&& $urandom_range(0, 9) == 0) begin
				// random burst of idle cycles
				send_gap <= $urandom_range(0, 13);
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				in_valid <= 1'b1;
				sample <= pending_samples.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall bursts plus an on-demand long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_epoch) begin
			hold_seen <= hold_epoch;
			hold_left <= LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idle_enable && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: check results, run the shadow model, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report("result with nothing expected", correlation, 0);
				end else begin
					corr_result_t want;
					want = expected_results.pop_front();
					if (correlation !== want.corr)
						report("correlation", correlation, want.corr);
					if (window_energy !== want.energy)
						report("window_energy", window_energy, want.energy);
					if (normalised_correlation !== want.norm)
						report("normalised_correlation", normalised_correlation,
							want.norm);
					if (want.norm == 16'sd32767 || want.norm == -16'sd32768)
						saturated_seen++;
					if (want.norm == 0)
						zero_norm_seen++;
				end
				results_checked++;
			end
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_and_shift(sample));
				samples_sent++;
			end
			if (cfg_valid && cfg_ready) begin
				apply_cfg(cfg_index, cfg_data);
				cfg_writes++;
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d quiet cycles", idle_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// one register write transaction
	task automatic write_reg(input logic [nsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [nsc_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(negedge clk);
		while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// upper data bits of the index write are junk the block must ignore
	task automatic load_tap(input int idx, input logic signed [15:0] v);
		logic [nsc_pkg::CFG_DATA_W-1:0] d;
		d = nsc_pkg::CFG_DATA_W'($urandom);
		d[nsc_pkg::TAP_INDEX_W-1:0] = nsc_pkg::TAP_INDEX_W'(idx);
		write_reg(nsc_pkg::CFG_TAP_INDEX, d);
		write_reg(nsc_pkg::CFG_TAP_VALUE, v);
	endtask

	// sender pause: wait until every result is back, then let the block settle
	task automatic drain();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		return 16'($urandom);
	endfunction

	// tap patterns: random, both extremes, sparse, all zero
	task automatic load_taps(input int mode);
		logic signed [15:0] v;
		for (int i = 0; i < WIN_LEN; i++) begin
			case (mode)
				0: v = rand_sample();
				1: v = -16'sd32768;
				2: v = 16'sd32767;
				3: v = ($urandom_range(0, 7) == 0) ? rand_sample() : 16'sd0;
				default: v = 16'sd0;
			endcase
			load_tap(i, v);
		end
	endtask

	// queue one stretch of samples of a given character
	task automatic queue_chunk(input int mode, input int count);
		logic signed [15:0] v;
		bit flip;
		int start;
		flip = $urandom_range(0, 1);
		start = $urandom_range(0, WIN_LEN - 1);
		for (int k = 0; k < count; k++) begin
			case (mode)
				// tap sequence replayed in order, the window lines up every 64 samples
				0: begin
					v = coeffs[(start + k) % WIN_LEN];
					if (flip)
						v = (v == -16'sd32768) ? 16'sd32767 : -v;
					if ($urandom_range(0, 15) == 0)
						v = v + 16'($urandom_range(0, 7)) - 16'sd4;
				end
				1: v = rand_sample();
				2: v = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
				3: v = 16'($urandom_range(0, 6)) - 16'sd3;
				default: v = 16'sd0;
			endcase
			pending_samples.push_back(v);
		end
	endtask

	initial begin
		logic signed [15:0] edge_samples[$];
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		idle_enable = 1'b1;
		hold_epoch = 0;
		idle_cycles = 0;
		error_count = 0;
		samples_sent = 0;
		results_checked = 0;
		cfg_writes = 0;
		saturated_seen = 0;
		zero_norm_seen = 0;
		win_head = 0;
		coeff_energy = 0;
		coeff_sel = '0;
		for (int i = 0; i < WIN_LEN; i++) begin
			win_samples[i] = '0;
			coeffs[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: taps still zero, so the normalized value must be zero
		edge_samples = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd1, -16'sd1,
			16'sh5555, -16'sh5556};
		foreach (edge_samples[i])
			pending_samples.push_back(edge_samples[i]);
		drain();

		// unused register indexes must leave the taps alone
		for (int idx = nsc_pkg::CFG_TAP_VALUE + 1; idx < (1 << nsc_pkg::CFG_IDX_W); idx++)
			write_reg(nsc_pkg::CFG_IDX_W'(idx), nsc_pkg::CFG_DATA_W'($urandom));
		// most negative taps against full scale samples of both signs
		load_taps(1);
		for (int k = 0; k < 9; k++)
			pending_samples.push_back(-16'sd32768);
		for (int k = 0; k < 9; k++)
			pending_samples.push_back(16'sd32767);
		drain();

		// random phases; the last one runs without any idling
		for (int ph = 0; ph < 6; ph++) begin
			load_taps(ph % 5);
			if (ph == 5)
				idle_enable = 1'b0;
			// over two full windows of replayed taps reach exact match and saturation
			queue_chunk(0, 2 * WIN_LEN + $urandom_range(0, 8));
			if (ph == 2) begin
				// long receiver hold-off while the sender keeps offering
				hold_epoch++;
			end
			while (pending_samples.size() < 160) begin
				int mode;
				mode = $urandom_range(0, 5);
				if (mode == 4)
					queue_chunk(4, WIN_LEN + $urandom_range(0, 4));
				else
					queue_chunk(mode > 4 ? 1 : mode, $urandom_range(10, 40));
			end
			drain();
		end

		$display("ran %0d samples and %0d register writes, %0d results compared",
			samples_sent, cfg_writes, results_checked);
		$display("tap sets random, extreme, sparse and zero; %0d saturated, %0d zero outputs",
			saturated_seen, zero_norm_seen);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", error_count,
				expected_results.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
